@@ hw/rtl/sas_pkg.sv @@
// Shared types and constants for the shelf atlas allocator.
`default_nettype none

package sas_pkg;

   // request kinds carried on req_tuser
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // field widths fixed by the interface
   localparam int SIZE_W   = 7;   // content width and height
   localparam int MARGIN_W = 3;   // pad_margin
   localparam int PAD_W    = 8;   // padded size: 127 + 2*7 fits in 8 bits
   localparam int PAGE_W   = 3;   // page_index
   localparam int POS_W    = 9;   // pos_x, pos_y

   localparam logic [MARGIN_W-1:0] PAD_MARGIN_RESET = 3'd1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_OPEN,
      ST_DONE
   } sas_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/sas_page_store.sv @@
// Page cursor memory with per-page valid bits; invalid pages read as zero.
`default_nettype none

module sas_page_store #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3,
   parameter int DATA_W = 30
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear_all,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // valid bits: cleared by reset or a clear request, set by any write
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ hw/rtl/sas_place_unit.sv @@
// Places one padded rectangle against one page's shelf cursor.
`default_nettype none

module sas_place_unit #(
   parameter int PAGE_WIDTH  = 512,
   parameter int PAGE_HEIGHT = 512,
   parameter int CW          = 10,
   parameter int CH          = 10
) (
   input  wire logic [CW-1:0]               cur_x,
   input  wire logic [CH-1:0]               cur_y,
   input  wire logic [CH-1:0]               cur_shelf,
   input  wire logic [sas_pkg::PAD_W-1:0]    pad_w,
   input  wire logic [sas_pkg::PAD_W-1:0]    pad_h,
   input  wire logic [sas_pkg::MARGIN_W-1:0] margin,
   output logic                             fits,
   output logic      [CW-1:0]               nxt_x,
   output logic      [CH-1:0]               nxt_y,
   output logic      [CH-1:0]               nxt_shelf,
   output logic      [sas_pkg::POS_W-1:0]   pos_x,
   output logic      [sas_pkg::POS_W-1:0]   pos_y
);

   localparam int SXW = ((CW > sas_pkg::PAD_W) ? CW : sas_pkg::PAD_W) + 1;
   localparam int SYW = ((CH > sas_pkg::PAD_W) ? CH : sas_pkg::PAD_W) + 1;
   localparam int OXW = ((CW + 1) > sas_pkg::POS_W) ? (CW + 1) : sas_pkg::POS_W;
   localparam int OYW = ((CH + 1) > sas_pkg::POS_W) ? (CH + 1) : sas_pkg::POS_W;

   logic           brk;
   logic [CW-1:0]  row_x;
   logic [CH-1:0]  row_y;
   logic [CH-1:0]  row_shelf;
   logic [OXW-1:0] org_x;
   logic [OYW-1:0] org_y;

   // row overrun starts a new shelf; shelf top stays within the page
   assign brk       = (SXW'(cur_x) + SXW'(pad_w)) > SXW'(PAGE_WIDTH);
   assign row_x     = brk ? '0 : cur_x;
   assign row_y     = brk ? CH'(cur_y + cur_shelf) : cur_y;
   assign row_shelf = brk ? '0 : cur_shelf;

   assign fits = (SYW'(row_y) + SYW'(pad_h)) <= SYW'(PAGE_HEIGHT);

   // cursor advance and shelf growth only on a fit; the break persists anyway
   always_comb begin
      nxt_x     = row_x;
      nxt_y     = row_y;
      nxt_shelf = row_shelf;
      if (fits) begin
         nxt_x = CW'(SXW'(row_x) + SXW'(pad_w));
         if (SYW'(pad_h) > SYW'(row_shelf)) begin
            nxt_shelf = CH'(pad_h);
         end
      end
   end

   // content origin sits one margin inside the padded origin
   assign org_x = OXW'(row_x) + OXW'(margin);
   assign org_y = OYW'(row_y) + OYW'(margin);
   assign pos_x = org_x[sas_pkg::POS_W-1:0];
   assign pos_y = org_y[sas_pkg::POS_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/shelf_atlas_allocator.sv @@
// Top level of the shelf atlas allocator: request sequencer and result register.
//
//   channel   direction  handshake              payload
//   req_      in         tvalid/tready          tuser: func; tdata: width, height
//   rsp_      out        tvalid/tready          tuser: granted; tdata: page, x, y, opened
//   csr_      in         wr_en (no wait)        wr_data: pad_margin
//
// An allocate walks the open pages in order, one memory read-modify-write per page, and
// opens a new page when none fits and a page is left. A clear or a rejected size goes
// straight to the result. The next request is taken in the idle state, which is entered
// as the result loads into the output register.
// Reset clears the page valid bits at once (no sweep); one page is open.
// A new request is accepted while a finished result still waits on rsp_tready.
`default_nettype none

module shelf_atlas_allocator #(
   parameter int PAGE_WIDTH  = 512,
   parameter int PAGE_HEIGHT = 512,
   parameter int MAX_PAGES   = 8,
   parameter int MAX_RECT    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tuser[0] func
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [0:0]  req_tuser,
   // request: tdata[6:0] box_w, [13:7] box_h, [15:14] zero
   input  wire logic [15:0] req_tdata,
   // result: tuser[0] granted
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [0:0]  rsp_tuser,
   // result: tdata[2:0] page_index, [11:3] pos_x, [20:12] pos_y, [21] opened_page
   output logic      [23:0] rsp_tdata,
   // configuration: pad_margin
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_wr_data
);

   localparam int CW  = $clog2(PAGE_WIDTH + 1);
   localparam int CH  = $clog2(PAGE_HEIGHT + 1);
   localparam int EW  = CW + 2 * CH;
   localparam int PIW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int OPW = $clog2(MAX_PAGES + 1);
   localparam int PGW = (PIW > sas_pkg::PAGE_W) ? PIW : sas_pkg::PAGE_W;
   localparam int LW  = ($clog2(MAX_RECT + 1) > sas_pkg::SIZE_W) ?
                        $clog2(MAX_RECT + 1) : sas_pkg::SIZE_W;
   localparam int SXW = ((CW > sas_pkg::PAD_W) ? CW : sas_pkg::PAD_W) + 1;
   localparam int SYW = ((CH > sas_pkg::PAD_W) ? CH : sas_pkg::PAD_W) + 1;

   sas_pkg::sas_state_type state_ff, state_in;

   logic [sas_pkg::MARGIN_W-1:0] pad_margin_ff;
   logic [OPW-1:0]               open_pages_ff, open_pages_in;
   logic [PIW-1:0]               page_ff, page_in;
   logic [sas_pkg::PAD_W-1:0]    aw_ff, aw_in, ah_ff, ah_in;

   logic                         res_granted_ff, res_granted_in;
   logic [sas_pkg::PAGE_W-1:0]   res_page_ff, res_page_in;
   logic [sas_pkg::POS_W-1:0]    res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                         res_opened_ff, res_opened_in;

   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [0:0]                   rsp_tuser_ff, rsp_tuser_in;
   logic [23:0]                  rsp_tdata_ff, rsp_tdata_in;

   // request decode
   logic [sas_pkg::SIZE_W-1:0]   req_w, req_h;
   logic [sas_pkg::PAD_W-1:0]    req_aw, req_ah;
   logic                         req_ok;

   assign req_w  = req_tdata[6:0];
   assign req_h  = req_tdata[13:7];
   assign req_aw = sas_pkg::PAD_W'(req_w) + sas_pkg::PAD_W'({pad_margin_ff, 1'b0});
   assign req_ah = sas_pkg::PAD_W'(req_h) + sas_pkg::PAD_W'({pad_margin_ff, 1'b0});
   assign req_ok = (req_w != '0) && (req_h != '0) &&
                   (LW'(req_w) <= LW'(MAX_RECT)) && (LW'(req_h) <= LW'(MAX_RECT)) &&
                   (SXW'(req_aw) <= SXW'(PAGE_WIDTH)) &&
                   (SYW'(req_ah) <= SYW'(PAGE_HEIGHT));

   // page store ports
   logic           st_clear, st_rd_en, st_wr_en;
   logic [PIW-1:0] st_rd_addr, st_wr_addr;
   logic [EW-1:0]  st_rd_data, st_wr_data;

   sas_page_store #(
      .DEPTH  (MAX_PAGES),
      .ADDR_W (PIW),
      .DATA_W (EW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .clear_all (st_clear),
      .rd_en     (st_rd_en),
      .rd_addr   (st_rd_addr),
      .rd_data   (st_rd_data),
      .wr_en     (st_wr_en),
      .wr_addr   (st_wr_addr),
      .wr_data   (st_wr_data)
   );

   // placement on the page just read; entry is {shelf, y, x}
   logic                       pl_fits;
   logic [CW-1:0]              pl_x;
   logic [CH-1:0]              pl_y, pl_shelf;
   logic [sas_pkg::POS_W-1:0]  pl_pos_x, pl_pos_y;

   sas_place_unit #(
      .PAGE_WIDTH  (PAGE_WIDTH),
      .PAGE_HEIGHT (PAGE_HEIGHT),
      .CW          (CW),
      .CH          (CH)
   ) u_place (
      .cur_x     (st_rd_data[CW-1:0]),
      .cur_y     (st_rd_data[CW+CH-1:CW]),
      .cur_shelf (st_rd_data[EW-1:CW+CH]),
      .pad_w     (aw_ff),
      .pad_h     (ah_ff),
      .margin    (pad_margin_ff),
      .fits      (pl_fits),
      .nxt_x     (pl_x),
      .nxt_y     (pl_y),
      .nxt_shelf (pl_shelf),
      .pos_x     (pl_pos_x),
      .pos_y     (pl_pos_y)
   );

   // sequencer state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sas_pkg::ST_IDLE;
         open_pages_ff <= OPW'(1);
         pad_margin_ff <= sas_pkg::PAD_MARGIN_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_pages_ff <= open_pages_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            pad_margin_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      aw_ff          <= aw_in;
      ah_ff          <= ah_in;
      res_granted_ff <= res_granted_in;
      res_page_ff    <= res_page_in;
      res_x_ff       <= res_x_in;
      res_y_ff       <= res_y_in;
      res_opened_ff  <= res_opened_in;
      rsp_tuser_ff   <= rsp_tuser_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   // next state and outputs
   always_comb begin
      state_in       = state_ff;
      open_pages_in  = open_pages_ff;
      page_in        = page_ff;
      aw_in          = aw_ff;
      ah_in          = ah_ff;
      res_granted_in = res_granted_ff;
      res_page_in    = res_page_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      res_opened_in  = res_opened_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in   = rsp_tuser_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      req_tready     = 1'b0;
      st_clear       = 1'b0;
      st_rd_en       = 1'b0;
      st_rd_addr     = page_ff;
      st_wr_en       = 1'b0;
      st_wr_addr     = page_ff;
      st_wr_data     = {pl_shelf, pl_y, pl_x};

      case (state_ff)
         sas_pkg::ST_IDLE: begin
            // no request is taken while reset is held
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               aw_in          = req_aw;
               ah_in          = req_ah;
               page_in        = '0;
               res_granted_in = 1'b0;
               res_page_in    = '0;
               res_x_in       = '0;
               res_y_in       = '0;
               res_opened_in  = 1'b0;
               state_in       = sas_pkg::ST_DONE;
               if (req_tuser[0] == sas_pkg::FUNC_CLEAR) begin
                  st_clear       = 1'b1;
                  res_granted_in = 1'b1;
               end else if (req_ok) begin
                  st_rd_en   = 1'b1;
                  st_rd_addr = '0;
                  state_in   = sas_pkg::ST_CHECK;
               end
            end
         end

         sas_pkg::ST_CHECK: begin
            // write back the page, shelf break included, and fetch the next open page if this one is full
            st_wr_en = 1'b1;
            if (pl_fits) begin
               res_granted_in = 1'b1;
               res_page_in    = sas_pkg::PAGE_W'(PGW'(page_ff));
               res_x_in       = pl_pos_x;
               res_y_in       = pl_pos_y;
               state_in       = sas_pkg::ST_DONE;
            end else if ((OPW'(page_ff) + OPW'(1)) < open_pages_ff) begin
               page_in    = PIW'(page_ff + PIW'(1));
               st_rd_en   = 1'b1;
               st_rd_addr = PIW'(page_ff + PIW'(1));
            end else if (open_pages_ff < OPW'(MAX_PAGES)) begin
               state_in = sas_pkg::ST_OPEN;
            end else begin
               state_in = sas_pkg::ST_DONE;
            end
         end

         sas_pkg::ST_OPEN: begin
            // a fresh page always takes a size-checked rectangle at its origin
            st_wr_en       = 1'b1;
            st_wr_addr     = open_pages_ff[PIW-1:0];
            st_wr_data     = {CH'(ah_ff), CH'(0), CW'(aw_ff)};
            open_pages_in  = open_pages_ff + OPW'(1);
            res_granted_in = 1'b1;
            res_page_in    = sas_pkg::PAGE_W'(PGW'(open_pages_ff[PIW-1:0]));
            res_x_in       = sas_pkg::POS_W'(pad_margin_ff);
            res_y_in       = sas_pkg::POS_W'(pad_margin_ff);
            res_opened_in  = 1'b1;
            state_in       = sas_pkg::ST_DONE;
         end

         sas_pkg::ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_granted_ff;
               rsp_tdata_in  = {2'b00, res_opened_ff, res_y_ff, res_x_ff, res_page_ff};
               state_in      = sas_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sas_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // page count stays within one and the page limit
   a_open_range: assert property (@(posedge clock) disable iff (reset)
      (open_pages_ff != '0) && (open_pages_ff <= OPW'(MAX_PAGES)))
      else $error("open page count out of range");

   // a page walk never looks past the open pages
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sas_pkg::ST_CHECK) |-> (OPW'(page_ff) < open_pages_ff))
      else $error("page walk beyond open pages");

   // read-modify-write never reads the entry being written in the same cycle
   a_rmw_hazard: assert property (@(posedge clock) disable iff (reset)
      (st_wr_en && st_rd_en) |-> (st_wr_addr != st_rd_addr))
      else $error("read and write to the same page entry");

   // an opened page is only reported on a granted request
   a_open_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[21]) |-> rsp_tuser[0])
      else $error("opened page without grant");

endmodule

`default_nettype wire

@@ bench/shelf_atlas_allocator_tb.sv @@
// Self-checking testbench for the shelf atlas allocator: random requests, scoreboard, stalls.
`timescale 1ns / 1ps

module shelf_atlas_allocator_tb;

   localparam int SHEET_WIDTH  = 512;
   localparam int SHEET_HEIGHT = 512;
   localparam int SHEET_COUNT  = 8;
   localparam int RECT_MAX     = 64;
   localparam int TAIL_CYCLES  = 16;      // longest request latency plus margin
   localparam int LONG_STALL   = 300;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic                       func;
      logic [sas_pkg::SIZE_W-1:0] w;
      logic [sas_pkg::SIZE_W-1:0] h;
   } atlas_req_type;

   typedef struct packed {
      logic                       granted;
      logic [sas_pkg::PAGE_W-1:0] page;
      logic [sas_pkg::POS_W-1:0]  pos_x;
      logic [sas_pkg::POS_W-1:0]  pos_y;
      logic                       opened;
   } placement_type;

   typedef enum int {SZ_BIG, SZ_MIXED, SZ_TINY} size_mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser = sas_pkg::FUNC_ALLOC;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [0:0]  rsp_tuser;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = '0;

   // request source and expected results
   atlas_req_type pending_reqs[$];
   placement_type placements_due[$];

   // predictor state
   logic [sas_pkg::MARGIN_W-1:0] margin_model;
   logic [9:0]                   cur_x[SHEET_COUNT];
   logic [9:0]                   cur_y[SHEET_COUNT];
   logic [9:0]                   shelf_h[SHEET_COUNT];
   logic [3:0]                   open_count;

   int send_idle_pct = 31;
   int recv_idle_pct = 46;
   int stall_left = 0;
   logic stall_kick = 1'b0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int accepted_count = 0;
   int clear_count = 0;
   int grant_count = 0;
   int refuse_count = 0;
   int open_events = 0;
   atlas_req_type drv_next;
   placement_type got;

   shelf_atlas_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // place a padded rectangle on one page; a row overrun breaks the shelf even on failure
   function automatic bit fit_on_page(int p, int aw, int ah, output int ox, output int oy);
      if (int'(cur_x[p]) + aw > SHEET_WIDTH) begin
         cur_y[p]   = cur_y[p] + shelf_h[p];
         cur_x[p]   = '0;
         shelf_h[p] = '0;
      end
      if (int'(cur_y[p]) + ah > SHEET_HEIGHT)
         return 1'b0;
      ox = int'(cur_x[p]) + int'(margin_model);
      oy = int'(cur_y[p]) + int'(margin_model);
      cur_x[p] = 10'(int'(cur_x[p]) + aw);
      if (ah > int'(shelf_h[p]))
         shelf_h[p] = 10'(ah);
      return 1'b1;
   endfunction

   // expected result of one request, updating the shadow page state
   function automatic placement_type predict_request(logic func,
                                                     logic [sas_pkg::SIZE_W-1:0] w,
                                                     logic [sas_pkg::SIZE_W-1:0] h);
      placement_type r;
      int aw, ah, n, ox, oy;
      r = '0;
      if (func == sas_pkg::FUNC_CLEAR) begin
         for (int i = 0; i < SHEET_COUNT; i++) begin
            cur_x[i] = '0;
            cur_y[i] = '0;
            shelf_h[i] = '0;
         end
         r.granted = 1'b1;
      end else begin
         aw = int'(w) + 2 * int'(margin_model);
         ah = int'(h) + 2 * int'(margin_model);
         if (w != 0 && h != 0 && w <= RECT_MAX && h <= RECT_MAX &&
             aw <= SHEET_WIDTH && ah <= SHEET_HEIGHT) begin
            n = (open_count > SHEET_COUNT) ? SHEET_COUNT : int'(open_count);
            for (int p = 0; p < n && !r.granted; p++) begin
               if (fit_on_page(p, aw, ah, ox, oy)) begin
                  r.granted = 1'b1;
                  r.page = sas_pkg::PAGE_W'(p);
                  r.pos_x = sas_pkg::POS_W'(ox);
                  r.pos_y = sas_pkg::POS_W'(oy);
               end
            end
            // nothing fits: open the next page if one is left
            if (!r.granted && n < SHEET_COUNT) begin
               cur_x[n] = '0;
               cur_y[n] = '0;
               shelf_h[n] = '0;
               open_count = 4'(n + 1);
               if (fit_on_page(n, aw, ah, ox, oy)) begin
                  r.granted = 1'b1;
                  r.page = sas_pkg::PAGE_W'(n);
                  r.pos_x = sas_pkg::POS_W'(ox);
                  r.pos_y = sas_pkg::POS_W'(oy);
                  r.opened = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   // request driver: predicts at acceptance, then offers the next pending request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            placements_due.push_back(predict_request(req_tuser[0], req_tdata[6:0],
                                                     req_tdata[13:7]));
            accepted_count++;
            if (req_tuser[0] == sas_pkg::FUNC_CLEAR)
               clear_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_next = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= drv_next.func;
               req_tdata  <= {2'b00, drv_next.h, drv_next.w};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset)
         stall_left <= 0;
      else if (stall_kick)
         stall_left <= LONG_STALL;
      else if (stall_left != 0)
         stall_left <= stall_left - 1;
   end

   // result ready with random stalls
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // result monitor and scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (placements_due.size() == 0) begin
            $error("result with no request outstanding: tuser %0h tdata %0h",
                   rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            got = placements_due.pop_front();
            check_field("granted", 16'(got.granted), 16'(rsp_tuser[0]));
            check_field("page_index", 16'(got.page), 16'(rsp_tdata[2:0]));
            check_field("pos_x", 16'(got.pos_x), 16'(rsp_tdata[11:3]));
            check_field("pos_y", 16'(got.pos_y), 16'(rsp_tdata[20:12]));
            check_field("opened_page", 16'(got.opened), 16'(rsp_tdata[21]));
            if (got.granted)
               grant_count++;
            else
               refuse_count++;
            if (got.opened)
               open_events++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic atlas_req_type mk_req(logic func, int w, int h);
      atlas_req_type r;
      r.func = func;
      r.w = sas_pkg::SIZE_W'(w);
      r.h = sas_pkg::SIZE_W'(h);
      return r;
   endfunction

   // one run of requests: usually a clear then allocations of one size mix, with some noise
   task automatic queue_burst(int count, size_mix_type mix, bit lead_clear);
      int lo, hi, roll;
      case (mix)
         SZ_BIG:   begin lo = 40; hi = RECT_MAX; end
         SZ_MIXED: begin lo = 1;  hi = RECT_MAX; end
         default:  begin lo = 1;  hi = 16; end
      endcase
      if (lead_clear)
         pending_reqs.push_back(mk_req(sas_pkg::FUNC_CLEAR, $urandom_range(127),
                                       $urandom_range(127)));
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(199);
         if (roll < 6)
            pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, $urandom_range(127),
                                          $urandom_range(127)));
         else if (roll == 6)
            pending_reqs.push_back(mk_req(sas_pkg::FUNC_CLEAR, $urandom_range(127),
                                          $urandom_range(127)));
         else
            pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, $urandom_range(hi, lo),
                                          $urandom_range(hi, lo)));
      end
   endtask

   task automatic queue_random(int target);
      int queued;
      int n;
      queued = 0;
      while (queued < target) begin
         n = $urandom_range(420, 20);
         if (n > target - queued)
            n = target - queued;
         queue_burst(n, size_mix_type'($urandom_range(2)), $urandom_range(3) != 0);
         queued += n;
      end
   endtask

   // wait until every request is answered, then let the pipeline settle
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || placements_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_margin(logic [sas_pkg::MARGIN_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      margin_model = v;
   endtask

   // stimulus sequence
   initial begin
      margin_model = sas_pkg::PAD_MARGIN_RESET;
      for (int i = 0; i < SHEET_COUNT; i++) begin
         cur_x[i] = '0;
         cur_y[i] = '0;
         shelf_h[i] = '0;
      end
      open_count = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, bad sizes, shelf break, clear
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 1, 1));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 64, 64));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 64, 1));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 1, 64));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 0, 5));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 5, 0));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 65, 10));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 10, 127));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 127, 127));
      for (int i = 0; i < 8; i++)
         pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 64, 64));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_CLEAR, 127, 127));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_ALLOC, 64, 64));
      pending_reqs.push_back(mk_req(sas_pkg::FUNC_CLEAR, 0, 0));
      wait_drained();

      // widest margin, sender idles less than receiver
      write_margin(3'd7);
      queue_random(470);
      wait_drained();

      // no margin, roles swapped, long receiver hold-off to back up the block
      write_margin(3'd0);
      send_idle_pct = 46;
      recv_idle_pct = 31;
      queue_random(470);
      @(posedge clock);
      stall_kick <= 1'b1;
      @(posedge clock);
      stall_kick <= 1'b0;
      wait_drained();

      // mid margins, no idling on either side
      write_margin(3'd4);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(230);
      wait_drained();
      write_margin(3'd3);
      queue_random(230);
      wait_drained();

      $display("tb: %0d requests checked: %0d granted, %0d refused, %0d clears, %0d page opens",
               accepted_count, grant_count, refuse_count, clear_count, open_events);
      $display("tb: pad margins 1, 7, 0, 4, 3 under mixed, swapped and no idling");
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
